// ===== rtl/pfpe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfpe_pkg
// shared constants and codes for the page framebuffer plot engine
// ----------------------------------------------------------------------------
package pfpe_pkg;

  localparam int COLUMNS     = 132;
  localparam int PAGES       = 8;
  localparam int ROWS        = 8 * PAGES;
  localparam int STORE_DEPTH = PAGES * COLUMNS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CRD_W       = 11;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam logic PIXEL_ON  = 1'b1;

  typedef enum logic [2:0] {
    OP_POINT       = 3'd0,
    OP_HLINE_COLOR = 3'd1,
    OP_HLINE_CLEAR = 3'd2,
    OP_HLINE_INV   = 3'd3,
    OP_VLINE_SET   = 3'd4,
    OP_VLINE_INV   = 3'd5,
    OP_READ        = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_SET    = 2'd1,
    MODE_INVERT = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_CLIP_X_LEFT   = 3'd0,
    REG_CLIP_X_RIGHT  = 3'd1,
    REG_CLIP_Y_TOP    = 3'd2,
    REG_CLIP_Y_BOTTOM = 3'd3,
    REG_DRAW_COLOR    = 3'd4
  } reg_t;

endpackage

// ===== rtl/pfpe_ram.sv =====
// ----------------------------------------------------------------------------
// pfpe_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pfpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1056
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/page_framebuffer_plot_engine_top.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_plot_engine_top
// point, line and readback engine over a page-organized 1bpp frame store
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1056-byte store to zero, one byte a cycle,
// and holds in_ready low until the sweep ends; configuration writes are
// taken throughout. One request is worked at a time, and in_ready is high
// only while the sequencer is idle. A readback reads the store, waits for
// the registered read data and loads it into the result. A point or line
// that passes the clip test steps through its clipped-in pixels in order:
// a pixel that lands in the store is a read-modify-write through the
// store's one read and one write port, one that falls outside it is flagged.
// A request rejected by the clip test, an out-of-range readback or an unused
// code goes straight to the result. in_ready returns in the same cycle that
// the loaded result shows on out_valid. The result sits in an output register,
// so the next request is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module page_framebuffer_plot_engine_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_operation,
  input  logic signed [9:0]                in_x_first,
  input  logic signed [9:0]                in_x_last,
  input  logic signed [9:0]                in_y_first,
  input  logic signed [9:0]                in_y_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_read_data,
  output logic                             out_out_of_store,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pfpe_pkg::PADDR_W-1:0]     paddr,
  input  logic [pfpe_pkg::PDATA_W-1:0]     pwdata,
  output logic [pfpe_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PIX,
    S_MOD,
    S_RDB,
    S_RDW,
    S_DONE
  } state_t;

  localparam int CW = pfpe_pkg::CRD_W;
  localparam int AW = pfpe_pkg::ADDR_W;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [7:0]            clip_x_left_r, clip_x_right_r;
  logic [5:0]            clip_y_top_r;
  logic [6:0]            clip_y_bottom_r;
  logic                  draw_color_r;
  logic signed [CW-1:0]  x_r, x_nxt;
  logic signed [CW-1:0]  y_r, y_nxt;
  logic signed [CW-1:0]  hi_r, hi_nxt;
  logic                  horiz_r, horiz_nxt;
  pfpe_pkg::mode_t       mode_r, mode_nxt;
  logic                  flag_r, flag_nxt;
  logic [7:0]            data_r, data_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_read_data_r, out_read_data_nxt;
  logic                  out_oos_r, out_oos_nxt;

  logic                  cfg_wr;
  pfpe_pkg::reg_t        cfg_idx;
  logic signed [CW-1:0]  xf_s, xl_s, yf_s, yl_s;
  logic signed [CW-1:0]  cl_s, cr_s, ct_s, cb_s, cb_m1_s;
  logic signed [CW-1:0]  h_end_s, h_lo, h_hi, v_lo, v_hi, cur;
  logic                  row_in, col_in, rd_oos, pix_oos;
  logic [pfpe_pkg::PAGE_W-1:0] page;
  logic [pfpe_pkg::COL_W-1:0]  col;
  logic [AW-1:0]         addr;
  logic [7:0]            mask, mod_byte;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [7:0]            ram_wdata;
  logic [7:0]            ram_rdata;
  pfpe_pkg::mode_t       color_mode;

  pfpe_ram #(
    .WIDTH (8),
    .DEPTH (pfpe_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = pfpe_pkg::reg_t'(paddr[4:2]);

  always_comb begin
    unique case (cfg_idx)
      pfpe_pkg::REG_CLIP_X_LEFT:   prdata = pfpe_pkg::PDATA_W'(clip_x_left_r);
      pfpe_pkg::REG_CLIP_X_RIGHT:  prdata = pfpe_pkg::PDATA_W'(clip_x_right_r);
      pfpe_pkg::REG_CLIP_Y_TOP:    prdata = pfpe_pkg::PDATA_W'(clip_y_top_r);
      pfpe_pkg::REG_CLIP_Y_BOTTOM: prdata = pfpe_pkg::PDATA_W'(clip_y_bottom_r);
      pfpe_pkg::REG_DRAW_COLOR:    prdata = pfpe_pkg::PDATA_W'(draw_color_r);
      default:                     prdata = '0;
    endcase
  end

  // request decode
  assign xf_s    = CW'(in_x_first);
  assign xl_s    = CW'(in_x_last);
  assign yf_s    = CW'(in_y_first);
  assign yl_s    = CW'(in_y_last);
  assign cl_s    = $signed(CW'(clip_x_left_r));
  assign cr_s    = $signed(CW'(clip_x_right_r));
  assign ct_s    = $signed(CW'(clip_y_top_r));
  assign cb_s    = $signed(CW'(clip_y_bottom_r));
  assign cb_m1_s = cb_s - CW'(1);

  assign row_in  = (yf_s >= ct_s) && (yf_s < cb_s);
  assign col_in  = (xf_s >= cl_s) && (xf_s <= cr_s);
  assign h_end_s = (pfpe_pkg::op_t'(in_operation) == pfpe_pkg::OP_POINT) ? xf_s : xl_s;
  assign h_lo    = (xf_s > cl_s) ? xf_s : cl_s;
  assign h_hi    = (h_end_s < cr_s) ? h_end_s : cr_s;
  assign v_lo    = (yf_s > ct_s) ? yf_s : ct_s;
  assign v_hi    = (yl_s < cb_m1_s) ? yl_s : cb_m1_s;
  assign rd_oos  = (xf_s < CW'(0)) || (yf_s < CW'(0)) ||
                   (xf_s >= CW'(pfpe_pkg::COLUMNS)) || (yf_s >= CW'(pfpe_pkg::PAGES));
  assign color_mode = (draw_color_r == pfpe_pkg::PIXEL_ON) ? pfpe_pkg::MODE_SET
                                                           : pfpe_pkg::MODE_CLEAR;

  // pixel datapath
  assign cur     = horiz_r ? x_r : y_r;
  assign pix_oos = (x_r >= CW'(pfpe_pkg::COLUMNS)) || (y_r >= CW'(pfpe_pkg::ROWS));
  assign page    = y_r[pfpe_pkg::PAGE_W+2:3];
  assign col     = x_r[pfpe_pkg::COL_W-1:0];
  assign addr    = AW'(page) * AW'(pfpe_pkg::COLUMNS) + AW'(col);
  assign mask    = 8'h80 >> y_r[2:0];

  always_comb begin
    case (mode_r)
      pfpe_pkg::MODE_SET:    mod_byte = ram_rdata | mask;
      pfpe_pkg::MODE_INVERT: mod_byte = ram_rdata ^ mask;
      default:               mod_byte = ram_rdata & ~mask;
    endcase
  end

  always_comb begin
    state_nxt         = state_r;
    clr_nxt           = clr_r;
    x_nxt             = x_r;
    y_nxt             = y_r;
    hi_nxt            = hi_r;
    horiz_nxt         = horiz_r;
    mode_nxt          = mode_r;
    flag_nxt          = flag_r;
    data_nxt          = data_r;
    out_valid_nxt     = out_valid_r & ~out_ready;
    out_read_data_nxt = out_read_data_r;
    out_oos_nxt       = out_oos_r;
    ram_we            = 1'b0;
    ram_waddr         = addr;
    ram_wdata         = mod_byte;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(pfpe_pkg::STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          flag_nxt  = 1'b0;
          data_nxt  = '0;
          state_nxt = S_DONE;
          case (pfpe_pkg::op_t'(in_operation)) inside
            pfpe_pkg::OP_POINT, pfpe_pkg::OP_HLINE_COLOR,
            pfpe_pkg::OP_HLINE_CLEAR, pfpe_pkg::OP_HLINE_INV: begin
              horiz_nxt = 1'b1;
              x_nxt     = h_lo;
              hi_nxt    = h_hi;
              y_nxt     = yf_s;
              if (pfpe_pkg::op_t'(in_operation) == pfpe_pkg::OP_HLINE_CLEAR) begin
                mode_nxt = pfpe_pkg::MODE_CLEAR;
              end else if (pfpe_pkg::op_t'(in_operation) == pfpe_pkg::OP_HLINE_INV) begin
                mode_nxt = pfpe_pkg::MODE_INVERT;
              end else begin
                mode_nxt = color_mode;
              end
              if (row_in) begin
                state_nxt = S_PIX;
              end
            end
            pfpe_pkg::OP_VLINE_SET, pfpe_pkg::OP_VLINE_INV: begin
              horiz_nxt = 1'b0;
              x_nxt     = xf_s;
              y_nxt     = v_lo;
              hi_nxt    = v_hi;
              mode_nxt  = (pfpe_pkg::op_t'(in_operation) == pfpe_pkg::OP_VLINE_SET)
                          ? pfpe_pkg::MODE_SET : pfpe_pkg::MODE_INVERT;
              if (col_in) begin
                state_nxt = S_PIX;
              end
            end
            pfpe_pkg::OP_READ: begin
              x_nxt = xf_s;
              y_nxt = yf_s <<< 3;
              if (rd_oos) begin
                flag_nxt = 1'b1;
              end else begin
                state_nxt = S_RDB;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PIX: begin
        if (cur > hi_r) begin
          state_nxt = S_DONE;
        end else if (pix_oos) begin
          flag_nxt = 1'b1;
          if (horiz_r) begin
            x_nxt = x_r + CW'(1);
          end else begin
            y_nxt = y_r + CW'(1);
          end
        end else begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        ram_we    = 1'b1;
        state_nxt = S_PIX;
        if (horiz_r) begin
          x_nxt = x_r + CW'(1);
        end else begin
          y_nxt = y_r + CW'(1);
        end
      end
      S_RDB: begin
        state_nxt = S_RDW;
      end
      S_RDW: begin
        data_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_read_data_nxt = data_r;
          out_oos_nxt       = flag_r;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_r           <= '0;
      out_valid_r     <= 1'b0;
      clip_x_left_r   <= 8'd0;
      clip_x_right_r  <= 8'(pfpe_pkg::COLUMNS - 1);
      clip_y_top_r    <= 6'd0;
      clip_y_bottom_r <= 7'(pfpe_pkg::ROWS);
      draw_color_r    <= pfpe_pkg::PIXEL_ON;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          pfpe_pkg::REG_CLIP_X_LEFT:   clip_x_left_r   <= pwdata[7:0];
          pfpe_pkg::REG_CLIP_X_RIGHT:  clip_x_right_r  <= pwdata[7:0];
          pfpe_pkg::REG_CLIP_Y_TOP:    clip_y_top_r    <= pwdata[5:0];
          pfpe_pkg::REG_CLIP_Y_BOTTOM: clip_y_bottom_r <= pwdata[6:0];
          pfpe_pkg::REG_DRAW_COLOR:    draw_color_r    <= pwdata[0];
          default: begin
          end
        endcase
      end
    end
    x_r             <= x_nxt;
    y_r             <= y_nxt;
    hi_r            <= hi_nxt;
    horiz_r         <= horiz_nxt;
    mode_r          <= mode_nxt;
    flag_r          <= flag_nxt;
    data_r          <= data_nxt;
    out_read_data_r <= out_read_data_nxt;
    out_oos_r       <= out_oos_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_out_of_store = out_oos_r;

endmodule

// ===== rtl/pfpe_checker.sv =====
// ----------------------------------------------------------------------------
// pfpe_checker
// port-level checks for the page framebuffer plot engine
// ----------------------------------------------------------------------------
module pfpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_out_of_store
);

  // store sweep keeps requests out after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high in the cycle after a request");

  // flagged results never carry data
  a_oos_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_store) |-> (out_read_data == 8'd0))
    else $error("out_of_store result with nonzero data");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_read_data) && $stable(out_out_of_store)))
    else $error("stalled result changed");

endmodule

bind page_framebuffer_plot_engine_top pfpe_checker u_pfpe_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the page framebuffer plot engine
// ----------------------------------------------------------------------------
// The stimulus process fills a queue of plot requests: first a directed set
// of points, lines and readbacks, then random requests under a series of
// clip windows written through the register port. Every accepted request
// runs through an in-bench model of the frame store and the clip logic, and
// each result is compared field by field with the oldest prediction. Both
// handshakes idle in short random bursts, except in the last part of the run.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]        op;
    logic signed [9:0] xf;
    logic signed [9:0] xl;
    logic signed [9:0] yf;
    logic signed [9:0] yl;
  } plot_req_t;

  typedef struct {
    logic [7:0] data;
    logic       oos;
  } plot_res_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [2:0]                    in_operation = '0;
  logic signed [9:0]             in_x_first = '0;
  logic signed [9:0]             in_x_last = '0;
  logic signed [9:0]             in_y_first = '0;
  logic signed [9:0]             in_y_last = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [7:0]                    out_read_data;
  logic                          out_out_of_store;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [pfpe_pkg::PADDR_W-1:0]  paddr = '0;
  logic [pfpe_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [pfpe_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  // frame store and register model
  logic [7:0] frame_model [pfpe_pkg::STORE_DEPTH];
  int         clip_left = 0;
  int         clip_right = 131;
  int         clip_top = 0;
  int         clip_bottom = 64;
  logic       color_model = pfpe_pkg::PIXEL_ON;

  plot_req_t  plot_requests[$];
  plot_res_t  plot_predictions[$];
  plot_req_t  drive_req;
  plot_req_t  seen_req;
  plot_res_t  want;
  logic       in_acc = 1'b0;
  bit         quiet = 1'b0;
  int         send_gap = 0;
  int         take_gap = 0;
  int         items_queued = 0;
  int         results_seen = 0;
  int         errors = 0;
  int         readbacks = 0;
  int         flagged = 0;
  int         windows = 0;

  page_framebuffer_plot_engine_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_x_first       (in_x_first),
    .in_x_last        (in_x_last),
    .in_y_first       (in_y_first),
    .in_y_last        (in_y_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_out_of_store (out_out_of_store),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("timeout at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

  // returns 1 when the pixel lies outside the store
  function automatic bit touch_pixel(int x, int y, pfpe_pkg::mode_t mode);
    int         idx;
    logic [7:0] mask;
    if (x < 0 || y < 0 || x >= pfpe_pkg::COLUMNS || (y >> 3) >= pfpe_pkg::PAGES)
      return 1'b1;
    idx  = (y >> 3) * pfpe_pkg::COLUMNS + x;
    mask = 8'h80 >> (y & 7);
    case (mode)
      pfpe_pkg::MODE_SET:   frame_model[idx] = frame_model[idx] | mask;
      pfpe_pkg::MODE_CLEAR: frame_model[idx] = frame_model[idx] & ~mask;
      default:              frame_model[idx] = frame_model[idx] ^ mask;
    endcase
    return 1'b0;
  endfunction

  function automatic bit hline_model(int x0, int x1, int y, pfpe_pkg::mode_t mode);
    bit flag;
    int lo;
    int hi;
    flag = 1'b0;
    if (y < clip_top || y >= clip_bottom) return 1'b0;
    lo = (x0 > clip_left) ? x0 : clip_left;
    hi = (x1 < clip_right) ? x1 : clip_right;
    for (int x = lo; x <= hi; x++) flag |= touch_pixel(x, y, mode);
    return flag;
  endfunction

  function automatic bit vline_model(int y0, int y1, int x, pfpe_pkg::mode_t mode);
    bit flag;
    int lo;
    int hi;
    flag = 1'b0;
    if (x < clip_left || x > clip_right) return 1'b0;
    lo = (y0 > clip_top) ? y0 : clip_top;
    hi = clip_bottom - 1;
    if (y1 < hi) hi = y1;
    for (int y = lo; y <= hi; y++) flag |= touch_pixel(x, y, mode);
    return flag;
  endfunction

  function automatic plot_res_t plot_predict(plot_req_t r);
    plot_res_t       res;
    int              xf;
    int              xl;
    int              yf;
    int              yl;
    pfpe_pkg::mode_t paint;
    xf       = r.xf;
    xl       = r.xl;
    yf       = r.yf;
    yl       = r.yl;
    res.data = '0;
    res.oos  = 1'b0;
    paint    = color_model ? pfpe_pkg::MODE_SET : pfpe_pkg::MODE_CLEAR;
    case (r.op)
      pfpe_pkg::OP_POINT: begin
        if (yf >= clip_top && yf < clip_bottom && xf >= clip_left && xf <= clip_right)
          res.oos = touch_pixel(xf, yf, paint);
      end
      pfpe_pkg::OP_HLINE_COLOR: res.oos = hline_model(xf, xl, yf, paint);
      pfpe_pkg::OP_HLINE_CLEAR: res.oos = hline_model(xf, xl, yf, pfpe_pkg::MODE_CLEAR);
      pfpe_pkg::OP_HLINE_INV:   res.oos = hline_model(xf, xl, yf, pfpe_pkg::MODE_INVERT);
      pfpe_pkg::OP_VLINE_SET:   res.oos = vline_model(yf, yl, xf, pfpe_pkg::MODE_SET);
      pfpe_pkg::OP_VLINE_INV:   res.oos = vline_model(yf, yl, xf, pfpe_pkg::MODE_INVERT);
      pfpe_pkg::OP_READ: begin
        if (xf < 0 || yf < 0 || xf >= pfpe_pkg::COLUMNS || yf >= pfpe_pkg::PAGES)
          res.oos = 1'b1;
        else
          res.data = frame_model[yf * pfpe_pkg::COLUMNS + xf];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick(int lo, int hi);
    logic signed [9:0] wide;
    if ($urandom_range(0, 9) == 0) begin
      wide = 10'($urandom);
      return int'(wide);
    end
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic plot_req_t random_req();
    plot_req_t         r;
    int                sel;
    logic signed [9:0] tmp;
    sel = $urandom_range(0, 99);
    if (sel < 12)      r.op = pfpe_pkg::OP_POINT;
    else if (sel < 22) r.op = pfpe_pkg::OP_HLINE_COLOR;
    else if (sel < 28) r.op = pfpe_pkg::OP_HLINE_CLEAR;
    else if (sel < 36) r.op = pfpe_pkg::OP_HLINE_INV;
    else if (sel < 46) r.op = pfpe_pkg::OP_VLINE_SET;
    else if (sel < 54) r.op = pfpe_pkg::OP_VLINE_INV;
    else if (sel < 98) r.op = pfpe_pkg::OP_READ;
    else               r.op = OP_UNUSED;
    r.xf = 10'(pick(-6, 137));
    r.xl = 10'(pick(-6, 137));
    r.yf = 10'(pick(-6, 69));
    r.yl = 10'(pick(-6, 69));
    case (r.op) inside
      pfpe_pkg::OP_HLINE_COLOR, pfpe_pkg::OP_HLINE_CLEAR, pfpe_pkg::OP_HLINE_INV: begin
        if (r.xf > r.xl && $urandom_range(0, 4) != 0) begin
          tmp  = r.xf;
          r.xf = r.xl;
          r.xl = tmp;
        end
      end
      pfpe_pkg::OP_VLINE_SET, pfpe_pkg::OP_VLINE_INV: begin
        if (r.yf > r.yl && $urandom_range(0, 4) != 0) begin
          tmp  = r.yf;
          r.yf = r.yl;
          r.yl = tmp;
        end
      end
      pfpe_pkg::OP_READ: begin
        r.xf = 10'(pick(-2, 133));
        r.yf = 10'(pick(-1, 8));
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_req(logic [2:0] op, int xf, int xl, int yf, int yl);
    plot_req_t r;
    r.op = op;
    r.xf = 10'(xf);
    r.xl = 10'(xl);
    r.yf = 10'(yf);
    r.yl = 10'(yl);
    plot_requests.push_back(r);
    items_queued++;
  endtask

  task automatic add_random(int count);
    repeat (count) begin
      plot_requests.push_back(random_req());
      items_queued++;
    end
  endtask

  task automatic cfg_write(pfpe_pkg::reg_t idx, int value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      pfpe_pkg::REG_CLIP_X_LEFT:   clip_left = value;
      pfpe_pkg::REG_CLIP_X_RIGHT:  clip_right = value;
      pfpe_pkg::REG_CLIP_Y_TOP:    clip_top = value;
      pfpe_pkg::REG_CLIP_Y_BOTTOM: clip_bottom = value;
      default:                     color_model = value[0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_window(int left, int right, int top, int bottom, int color);
    cfg_write(pfpe_pkg::REG_CLIP_X_LEFT, left);
    cfg_write(pfpe_pkg::REG_CLIP_X_RIGHT, right);
    cfg_write(pfpe_pkg::REG_CLIP_Y_TOP, top);
    cfg_write(pfpe_pkg::REG_CLIP_Y_BOTTOM, bottom);
    cfg_write(pfpe_pkg::REG_DRAW_COLOR, color);
    windows++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (results_seen != items_queued) @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_acc) begin
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (plot_requests.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      send_gap = $urandom_range(0, 2);
    end else if (plot_requests.size() != 0) begin
      drive_req = plot_requests.pop_front();
      in_operation <= drive_req.op;
      in_x_first   <= drive_req.xf;
      in_x_last    <= drive_req.xl;
      in_y_first   <= drive_req.yf;
      in_y_last    <= drive_req.yl;
      in_valid     <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (take_gap > 0) begin
      out_ready <= 1'b0;
      take_gap--;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      take_gap = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      seen_req.op = in_operation;
      seen_req.xf = in_x_first;
      seen_req.xl = in_x_last;
      seen_req.yf = in_y_first;
      seen_req.yl = in_y_last;
      if (in_operation == pfpe_pkg::OP_READ) readbacks++;
      plot_predictions.push_back(plot_predict(seen_req));
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (plot_predictions.size() == 0) begin
        errors++;
        $display("%0t: expected no result, got data %h flag %b", $time, out_read_data,
                 out_out_of_store);
      end else begin
        want = plot_predictions.pop_front();
        if (want.oos) flagged++;
        if (out_read_data !== want.data) begin
          errors++;
          $display("%0t: read_data expected %h got %h", $time, want.data, out_read_data);
        end
        if (out_out_of_store !== want.oos) begin
          errors++;
          $display("%0t: out_of_store expected %b got %b", $time, want.oos,
                   out_out_of_store);
        end
      end
    end
  end

  initial begin
    int l;
    int r;
    int t;
    int b;
    foreach (frame_model[i]) frame_model[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset window, white
    add_req(pfpe_pkg::OP_READ, 0, 0, 0, 0);
    add_req(pfpe_pkg::OP_POINT, 0, 0, 0, 0);
    add_req(pfpe_pkg::OP_POINT, 131, 0, 63, 0);
    add_req(pfpe_pkg::OP_POINT, -1, 0, 5, 0);
    add_req(pfpe_pkg::OP_POINT, 5, 0, 64, 0);
    add_req(pfpe_pkg::OP_HLINE_COLOR, -512, 511, 0, 0);
    add_req(pfpe_pkg::OP_HLINE_INV, 0, 131, 9, 0);
    add_req(pfpe_pkg::OP_HLINE_CLEAR, 10, 20, 9, 0);
    add_req(pfpe_pkg::OP_HLINE_COLOR, 50, 40, 3, 0);
    add_req(pfpe_pkg::OP_VLINE_SET, 7, 0, -512, 511);
    add_req(pfpe_pkg::OP_VLINE_INV, 7, 0, 3, 12);
    add_req(pfpe_pkg::OP_VLINE_SET, 132, 0, 0, 63);
    add_req(pfpe_pkg::OP_READ, 0, 0, 0, 0);
    add_req(pfpe_pkg::OP_READ, 131, 0, 7, 0);
    add_req(pfpe_pkg::OP_READ, 7, 0, 1, 0);
    add_req(pfpe_pkg::OP_READ, 20, 0, 1, 0);
    add_req(pfpe_pkg::OP_READ, -1, 0, 0, 0);
    add_req(pfpe_pkg::OP_READ, 0, 0, -1, 0);
    add_req(pfpe_pkg::OP_READ, 132, 0, 0, 0);
    add_req(pfpe_pkg::OP_READ, 0, 0, 8, 0);
    add_req(pfpe_pkg::OP_READ, 511, 0, 511, 0);
    add_req(OP_UNUSED, -512, 511, -512, 511);
    wait_drained();

    // one-pixel window in the far corner, colour cleared
    set_window(131, 131, 63, 64, 0);
    add_req(pfpe_pkg::OP_VLINE_SET, 131, 0, -512, 511);
    add_req(pfpe_pkg::OP_READ, 131, 0, 7, 0);
    add_req(pfpe_pkg::OP_POINT, 131, 0, 63, 0);
    add_req(pfpe_pkg::OP_READ, 131, 0, 7, 0);
    add_random(100);
    wait_drained();

    set_window(0, 131, 0, 64, 1);
    add_random(200);
    wait_drained();

    // inverted window, then a single column with no rows
    set_window(100, 20, 40, 10, 1);
    add_random(80);
    wait_drained();
    set_window(0, 0, 0, 0, 0);
    add_random(60);
    wait_drained();

    repeat (5) begin
      l = $urandom_range(0, 131);
      r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131) : $urandom_range(l, 131);
      t = $urandom_range(0, 63);
      b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(t, 64);
      set_window(l, r, t, b, $urandom_range(0, 1));
      add_random(100);
      wait_drained();
    end

    // back to back, no idling
    set_window(0, 131, 0, 64, $urandom_range(0, 1));
    quiet = 1'b1;
    add_random(160);
    wait_drained();
    repeat (20) @(negedge clk);

    if (plot_predictions.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted results never arrived", $time, plot_predictions.size());
    end
    $display("%0d requests checked, %0d readbacks, %0d out-of-store flags",
             results_seen, readbacks, flagged);
    $display("%0d clip windows written, %0d errors", windows, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
